>>> rtl/snb_pkg.sv
// Package with the constants and types shared by the short name builder modules.
`timescale 1ns / 1ps

package snb_pkg;

  localparam int unsigned BaseLen = 8;
  localparam int unsigned ExtLen  = 3;
  localparam int unsigned NameLen = BaseLen + ExtLen;

  localparam logic [7:0] SpaceChar     = 8'h20;
  localparam logic [7:0] DotChar       = 8'h2E;
  localparam logic [7:0] SlashChar     = 8'h2F;
  localparam logic [7:0] BackslashChar = 8'h5C;

  // Classification of one path byte, produced by the character decoder.
  typedef struct packed {
    logic       separator;
    logic       dot;
    logic       allowed;
    logic [7:0] upper_code;
  } char_class_t;

endpackage

>>> rtl/snb_char_class.sv
// Character decoder: separators, dot, the allowed short name set and upper-casing.
`timescale 1ns / 1ps

module snb_char_class (
  input  logic [7:0]          char_code_i,
  output snb_pkg::char_class_t class_o
);

  logic is_lower;
  logic is_upper;
  logic is_digit;
  logic is_symbol;

  assign is_lower = (char_code_i >= 8'h61) && (char_code_i <= 8'h7A);
  assign is_upper = (char_code_i >= 8'h41) && (char_code_i <= 8'h5A);
  assign is_digit = (char_code_i >= 8'h30) && (char_code_i <= 8'h39);

  // Punctuation permitted in short names: $ % ' - _ @ ~ ` ! ( ) { } ^ # &
  always_comb begin
    unique case (char_code_i)
      8'h24, 8'h25, 8'h27, 8'h2D, 8'h5F, 8'h40, 8'h7E, 8'h60,
      8'h21, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5E, 8'h23, 8'h26: is_symbol = 1'b1;
      default: is_symbol = 1'b0;
    endcase
  end

  assign class_o.separator  = (char_code_i == snb_pkg::SlashChar) ||
                              (char_code_i == snb_pkg::BackslashChar);
  assign class_o.dot        = (char_code_i == snb_pkg::DotChar);
  assign class_o.allowed    = is_lower || is_upper || is_digit || is_symbol;
  assign class_o.upper_code = is_lower ? (char_code_i - 8'h20) : char_code_i;

endmodule

>>> rtl/short_name_builder_top.sv
// Top level of the 8.3 short name builder: name accumulation and result register.
//
//  Channel  | Direction | Payload
//  s_axis   | in        | tdata[7:0] = char_code, tlast = last_char
//  m_axis   | out       | tdata[63:0] = base_part, tdata[87:64] = extension_part,
//           |           | tuser = status
//
// One path byte is taken every cycle; a result appears in the cycle after its final
// byte is taken. The name buffer and counters update in the accepting cycle.
// The input stalls only when a finished result waits in the output register and the
// downstream side is not ready. Reset leaves the buffer all spaces and no result held.
`timescale 1ns / 1ps

module short_name_builder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic        s_axis_tlast_i,   // last_char
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,   // [63:0] base_part, [87:64] extension_part
  output logic        m_axis_tuser_o    // status
);

  localparam int unsigned NameLen = snb_pkg::NameLen;

  snb_pkg::char_class_t char_class;

  logic [7:0] name_q [NameLen];
  logic [7:0] name_d [NameLen];
  logic [3:0] base_count_q, base_count_d;
  logic [1:0] ext_count_q, ext_count_d;
  logic       in_ext_q, in_ext_d;
  logic       bad_q, bad_d;

  logic        out_valid_q;
  logic        status_q;
  logic [87:0] data_q;

  logic        in_fire;
  logic        result_bad;
  logic [63:0] base_word;
  logic [23:0] ext_word;

  snb_char_class u_char_class (
    .char_code_i (s_axis_tdata_i),
    .class_o     (char_class)
  );

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    name_d       = name_q;
    base_count_d = base_count_q;
    ext_count_d  = ext_count_q;
    in_ext_d     = in_ext_q;
    bad_d        = bad_q;
    priority if (char_class.separator) begin
      for (int i = 0; i < NameLen; i++) name_d[i] = snb_pkg::SpaceChar;
      base_count_d = '0;
      ext_count_d  = '0;
      in_ext_d     = 1'b0;
      bad_d        = 1'b0;
    end else if (char_class.dot && !in_ext_q) begin
      // A dot with no base character yet means an empty name.
      if (base_count_q == '0) bad_d = 1'b1;
      in_ext_d = 1'b1;
    end else if (!char_class.allowed) begin
      bad_d = 1'b1;
    end else if (!in_ext_q) begin
      if (base_count_q >= 4'(snb_pkg::BaseLen)) begin
        bad_d = 1'b1;
      end else begin
        name_d[base_count_q] = char_class.upper_code;
        base_count_d         = base_count_q + 4'd1;
      end
    end else begin
      if (ext_count_q >= 2'(snb_pkg::ExtLen)) begin
        bad_d = 1'b1;
      end else begin
        name_d[4'(snb_pkg::BaseLen) + {2'b00, ext_count_q}] = char_class.upper_code;
        ext_count_d = ext_count_q + 2'd1;
      end
    end
  end

  assign result_bad = bad_d || (base_count_d == '0);
  assign base_word  = {name_d[0], name_d[1], name_d[2], name_d[3],
                       name_d[4], name_d[5], name_d[6], name_d[7]};
  assign ext_word   = {name_d[8], name_d[9], name_d[10]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NameLen; i++) name_q[i] <= snb_pkg::SpaceChar;
      base_count_q <= '0;
      ext_count_q  <= '0;
      in_ext_q     <= 1'b0;
      bad_q        <= 1'b0;
    end else if (in_fire) begin
      if (s_axis_tlast_i) begin
        // The path is finished, so the next transaction starts a fresh name.
        for (int i = 0; i < NameLen; i++) name_q[i] <= snb_pkg::SpaceChar;
        base_count_q <= '0;
        ext_count_q  <= '0;
        in_ext_q     <= 1'b0;
        bad_q        <= 1'b0;
      end else begin
        name_q       <= name_d;
        base_count_q <= base_count_d;
        ext_count_q  <= ext_count_d;
        in_ext_q     <= in_ext_d;
        bad_q        <= bad_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && s_axis_tlast_i) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tlast_i) begin
      status_q <= result_bad;
      data_q   <= result_bad ? '0 : {ext_word, base_word};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = status_q;

endmodule
